// ===== design/phs_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, codes and helpers for the pixel histogram with plane select.
// Used by the core and the testbench; depends on nothing else.
package phs_pkg;

  localparam int COUNT_BITS = 24;
  localparam int BIN_BITS   = 8;
  localparam int BIN_COUNT  = 1 << BIN_BITS;
  localparam int TOTAL_BITS = 24;
  localparam int SAMPLE_BITS = 8;
  localparam int KIND_BITS  = 2;
  localparam int PLANE_BITS = 2;
  localparam int PADDR_BITS = 3;
  localparam int PDATA_BITS = 32;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = {TOTAL_BITS{1'b1}};

  // Image kinds
  localparam logic [KIND_BITS-1:0] KIND_BITMAP = 2'd0;
  localparam logic [KIND_BITS-1:0] KIND_GRAY   = 2'd1;
  localparam logic [KIND_BITS-1:0] KIND_COLOR  = 2'd2;

  // Planes of a colour image
  localparam logic [PLANE_BITS-1:0] PLANE_GRAY  = 2'd0;
  localparam logic [PLANE_BITS-1:0] PLANE_RED   = 2'd1;
  localparam logic [PLANE_BITS-1:0] PLANE_GREEN = 2'd2;
  localparam logic [PLANE_BITS-1:0] PLANE_BLUE  = 2'd3;

  // Item modes
  localparam logic MODE_ACCUMULATE = 1'b0;
  localparam logic MODE_READ       = 1'b1;

  // Register index, taken from address bit 2
  localparam logic REG_IMAGE_KIND = 1'b0;
  localparam logic REG_PLANE      = 1'b1;

  // Clamp a bin count to the width of the reported total.
  function automatic logic [TOTAL_BITS-1:0] clamp_total(input logic [COUNT_BITS-1:0] count);
    logic [63:0] wide;
    wide = 64'(count);
    if (wide > 64'(TOTAL_MAX)) begin
      return TOTAL_MAX;
    end
    return TOTAL_BITS'(wide);
  endfunction

endpackage

// ===== design/pixel_histogram_plane_select_core.sv =====
`timescale 1ns / 1ps
// Pixel histogram core: 256 saturating bins in one RAM, updated by read-modify-write.
// Throughput: one pixel transfer per cycle outside the clearing pass; a read waits while
// another read is in the modify stage or the single output register has no free slot.
// A read result passes the modify stage and the output register. Back-to-back pixels on
// one bin are forwarded. Reset: control registers take reset values, then a pass zeroes
// the RAM; in_ready stays low during the pass, configuration writes are taken throughout.
module pixel_histogram_plane_select_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_mode,
  input  logic                                 in_pixel_valid,
  input  logic [phs_pkg::SAMPLE_BITS-1:0]      in_gray_sample,
  input  logic [phs_pkg::SAMPLE_BITS-1:0]      in_red_sample,
  input  logic [phs_pkg::SAMPLE_BITS-1:0]      in_green_sample,
  input  logic [phs_pkg::SAMPLE_BITS-1:0]      in_blue_sample,
  input  logic [phs_pkg::BIN_BITS-1:0]         in_bin_select,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [phs_pkg::BIN_BITS-1:0]         out_bin_number,
  output logic [phs_pkg::TOTAL_BITS-1:0]       out_bin_total,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [phs_pkg::PADDR_BITS-1:0]       paddr,
  input  logic [phs_pkg::PDATA_BITS-1:0]       pwdata,
  output logic [phs_pkg::PDATA_BITS-1:0]       prdata,
  output logic                                 pready
);
  import phs_pkg::*;

  // Configuration registers
  logic [KIND_BITS-1:0]  image_kind_r;
  logic [PLANE_BITS-1:0] plane_r;
  logic                  cfg_write;

  // Clearing pass
  logic                  clr_busy_r;
  logic [BIN_BITS-1:0]   clr_addr_r;

  // Front end
  logic                  in_xfer;
  logic                  do_count;
  logic                  do_read;
  logic [SAMPLE_BITS-1:0] plane_sample;
  logic [BIN_BITS-1:0]   rd_addr;

  // Modify stage
  logic                  s1_valid_r;
  logic                  s1_read_r;
  logic [BIN_BITS-1:0]   s1_addr_r;
  logic                  fwd_hit_r;
  logic [COUNT_BITS-1:0] fwd_data_r;
  logic [COUNT_BITS-1:0] rd_data;
  logic [COUNT_BITS-1:0] cur_count;
  logic [COUNT_BITS-1:0] new_count;

  // RAM write port
  logic                  wr_en;
  logic [BIN_BITS-1:0]   wr_addr;
  logic [COUNT_BITS-1:0] wr_data;

  // Output register
  logic                  out_valid_r;
  logic [BIN_BITS-1:0]   out_bin_number_r;
  logic [TOTAL_BITS-1:0] out_bin_total_r;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      REG_IMAGE_KIND: prdata[KIND_BITS-1:0]  = image_kind_r;
      REG_PLANE:      prdata[PLANE_BITS-1:0] = plane_r;
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_kind_r <= KIND_GRAY;
      plane_r      <= PLANE_GRAY;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_IMAGE_KIND: image_kind_r <= pwdata[KIND_BITS-1:0];
        REG_PLANE:      plane_r      <= pwdata[PLANE_BITS-1:0];
        default:        ;
      endcase
    end
  end

  always_comb begin
    unique case (plane_r)
      PLANE_GRAY:  plane_sample = in_gray_sample;
      PLANE_RED:   plane_sample = in_red_sample;
      PLANE_GREEN: plane_sample = in_green_sample;
      PLANE_BLUE:  plane_sample = in_blue_sample;
      default:     plane_sample = in_gray_sample;
    endcase
  end

  // A read needs the output slot to be free by the time its result arrives, and
  // no other read may be in the modify stage at the same time.
  always_comb begin
    if (clr_busy_r) begin
      in_ready = 1'b0;
    end else if (in_mode == MODE_READ) begin
      in_ready = !(s1_valid_r && s1_read_r) && (!out_valid_r || out_ready);
    end else begin
      in_ready = 1'b1;
    end
  end

  assign in_xfer  = in_valid && in_ready;
  assign do_read  = in_xfer && (in_mode == MODE_READ);
  assign do_count = in_xfer && (in_mode == MODE_ACCUMULATE) && in_pixel_valid &&
                    ((image_kind_r == KIND_GRAY) || (image_kind_r == KIND_COLOR));

  always_comb begin
    if (in_mode == MODE_READ) begin
      rd_addr = in_bin_select;
    end else if (image_kind_r == KIND_COLOR) begin
      rd_addr = BIN_BITS'(plane_sample);
    end else begin
      rd_addr = BIN_BITS'(in_gray_sample);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == BIN_BITS'(BIN_COUNT - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s1_read_r  <= 1'b0;
      fwd_hit_r  <= 1'b0;
    end else begin
      s1_valid_r <= do_count || do_read;
      s1_read_r  <= do_read;
      // The RAM read issued this cycle misses the write landing at the same edge.
      fwd_hit_r  <= wr_en && (wr_addr == rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    s1_addr_r  <= rd_addr;
    fwd_data_r <= wr_data;
  end

  assign cur_count = fwd_hit_r ? fwd_data_r : rd_data;

  always_comb begin
    if (s1_read_r) begin
      new_count = '0;
    end else if (cur_count == COUNT_MAX) begin
      new_count = cur_count;
    end else begin
      new_count = cur_count + 1'b1;
    end
  end

  always_comb begin
    if (clr_busy_r) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr_r;
      wr_data = '0;
    end else begin
      wr_en   = s1_valid_r;
      wr_addr = s1_addr_r;
      wr_data = new_count;
    end
  end

  phs_bin_ram #(
    .ADDR_BITS (BIN_BITS),
    .DATA_BITS (COUNT_BITS)
  ) u_bin_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_valid_r && s1_read_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r && s1_read_r) begin
      out_bin_number_r <= s1_addr_r;
      out_bin_total_r  <= clamp_total(cur_count);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_bin_number = out_bin_number_r;
  assign out_bin_total  = out_bin_total_r;

endmodule

// ===== design/phs_bin_ram.sv =====
`timescale 1ns / 1ps
// Single-port-write, single-port-read synchronous RAM holding the histogram bins.
// Read data is registered; no dependencies.
module phs_bin_ram #(
  parameter int ADDR_BITS = 8,
  parameter int DATA_BITS = 24
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [ADDR_BITS-1:0] wr_addr,
  input  logic [DATA_BITS-1:0] wr_data,
  input  logic [ADDR_BITS-1:0] rd_addr,
  output logic [DATA_BITS-1:0] rd_data
);

  logic [DATA_BITS-1:0] mem [(1 << ADDR_BITS)];
  logic [DATA_BITS-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== verif/tb_pixel_histogram_plane_select_core.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for pixel_histogram_plane_select_core: directed and random pixel and
// bin-read transfers, checked against a behavioural histogram kept in the testbench.
// Depends on phs_pkg, the core RTL and its bin RAM only.
module tb_pixel_histogram_plane_select_core;
  import phs_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int IDLE_PERCENT  = 26;
  localparam int RANDOM_PHASES = 20;
  localparam int PHASE_ITEMS   = 100;
  localparam int SETTLE_CYCLES = 4;

  localparam logic [KIND_BITS-1:0]  KIND_UNUSED     = 2'd3;
  localparam logic [PADDR_BITS-1:0] ADDR_IMAGE_KIND = {REG_IMAGE_KIND, 2'b00};
  localparam logic [PADDR_BITS-1:0] ADDR_PLANE      = {REG_PLANE, 2'b00};

  typedef struct packed {
    logic                   mode;
    logic                   pixel_valid;
    logic [SAMPLE_BITS-1:0] gray;
    logic [SAMPLE_BITS-1:0] red;
    logic [SAMPLE_BITS-1:0] green;
    logic [SAMPLE_BITS-1:0] blue;
    logic [BIN_BITS-1:0]    bin_select;
  } hist_item_t;

  typedef struct packed {
    logic [BIN_BITS-1:0]   bin_number;
    logic [TOTAL_BITS-1:0] bin_total;
  } bin_report_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_ready;
  logic                   in_mode;
  logic                   in_pixel_valid;
  logic [SAMPLE_BITS-1:0] in_gray_sample;
  logic [SAMPLE_BITS-1:0] in_red_sample;
  logic [SAMPLE_BITS-1:0] in_green_sample;
  logic [SAMPLE_BITS-1:0] in_blue_sample;
  logic [BIN_BITS-1:0]    in_bin_select;
  logic                   out_valid;
  logic                   out_ready;
  logic [BIN_BITS-1:0]    out_bin_number;
  logic [TOTAL_BITS-1:0]  out_bin_total;
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [PADDR_BITS-1:0]  paddr;
  logic [PDATA_BITS-1:0]  pwdata;
  logic [PDATA_BITS-1:0]  prdata;
  logic                   pready;

  // Behavioural copy of the histogram and its registers.
  logic [COUNT_BITS-1:0]  hist_counts [BIN_COUNT];
  logic [KIND_BITS-1:0]   kind_reg;
  logic [PLANE_BITS-1:0]  plane_reg;
  bin_report_t            pending_reports [$];
  bin_report_t            oldest_report;

  int unsigned            error_count;
  int unsigned            cycle_count;
  bit                     no_idle;

  pixel_histogram_plane_select_core DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_mode         (in_mode),
    .in_pixel_valid  (in_pixel_valid),
    .in_gray_sample  (in_gray_sample),
    .in_red_sample   (in_red_sample),
    .in_green_sample (in_green_sample),
    .in_blue_sample  (in_blue_sample),
    .in_bin_select   (in_bin_select),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_bin_number  (out_bin_number),
    .out_bin_total   (out_bin_total),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    $display("ERROR at cycle %0d: %s", cycle_count, what);
    error_count++;
  endtask

  // Applies one accepted transfer to the histogram copy and queues any bin report it causes.
  task automatic account_item(input hist_item_t it);
    bin_report_t            rep;
    logic [SAMPLE_BITS-1:0] sample;
    logic                   counted;
    if (it.mode == MODE_READ) begin
      rep.bin_number = it.bin_select;
      rep.bin_total  = (64'(hist_counts[it.bin_select]) > 64'(TOTAL_MAX)) ?
                       TOTAL_MAX : TOTAL_BITS'(hist_counts[it.bin_select]);
      pending_reports.push_back(rep);
      hist_counts[it.bin_select] = '0;
    end else if (it.pixel_valid) begin
      counted = 1'b1;
      sample  = it.gray;
      case (kind_reg)
        KIND_GRAY: sample = it.gray;
        KIND_COLOR: begin
          case (plane_reg)
            PLANE_GRAY:  sample = it.gray;
            PLANE_RED:   sample = it.red;
            PLANE_GREEN: sample = it.green;
            default:     sample = it.blue;
          endcase
        end
        default: counted = 1'b0;
      endcase
      // A full bin holds its count; a full 24-bit bin is out of reach in a run of this length.
      if (counted && hist_counts[sample] != COUNT_MAX) begin
        hist_counts[sample] = hist_counts[sample] + 1'b1;
      end
    end
  endtask

  // Called at a rising edge; returns at the edge where the transfer took place.
  task automatic send_item(input hist_item_t it);
    while (!no_idle && $urandom_range(99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_mode         <= it.mode;
    in_pixel_valid  <= it.pixel_valid;
    in_gray_sample  <= it.gray;
    in_red_sample   <= it.red;
    in_green_sample <= it.green;
    in_blue_sample  <= it.blue;
    in_bin_select   <= it.bin_select;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    account_item(it);
  endtask

  // Stops sending and waits for every queued report, then lets the pipeline settle.
  task automatic wait_for_reports();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes a register with random upper data bits, then reads it back.
  task automatic cfg_write(input logic [PADDR_BITS-1:0] addr, input logic [1:0] value);
    logic [PDATA_BITS-1:0] wdata;
    wdata      = $urandom();
    wdata[1:0] = value;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr == ADDR_IMAGE_KIND) begin
      kind_reg = value;
    end else begin
      plane_reg = value;
    end
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== PDATA_BITS'(value)) begin
      report_mismatch($sformatf("register at 0x%0h reads 0x%0h, written 0x%0h",
                                addr, prdata, value));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  function automatic hist_item_t pixel_item(input logic valid, input logic [7:0] g,
                                            input logic [7:0] r, input logic [7:0] gr,
                                            input logic [7:0] b);
    hist_item_t it;
    it.mode        = MODE_ACCUMULATE;
    it.pixel_valid = valid;
    it.gray        = g;
    it.red         = r;
    it.green       = gr;
    it.blue        = b;
    it.bin_select  = 8'($urandom());
    return it;
  endfunction

  // The pixel fields of a read carry noise, since the core must ignore them.
  function automatic hist_item_t read_item(input logic [BIN_BITS-1:0] sel);
    hist_item_t  it;
    logic [63:0] noise;
    noise         = {$urandom(), $urandom()};
    it            = noise[$bits(hist_item_t)-1:0];
    it.mode       = MODE_READ;
    it.bin_select = sel;
    return it;
  endfunction

  // A narrow pool of values makes repeated bins, forwarding and reads of live bins common.
  function automatic logic [7:0] pick_value(input bit narrow);
    if (!narrow) begin
      return 8'($urandom_range(255));
    end
    return ($urandom_range(3) == 0) ? 8'hFF : 8'($urandom_range(7));
  endfunction

  function automatic hist_item_t random_item(input bit narrow);
    hist_item_t it;
    it.mode        = ($urandom_range(99) < 20) ? MODE_READ : MODE_ACCUMULATE;
    it.pixel_valid = ($urandom_range(99) < 85);
    it.gray        = pick_value(narrow);
    it.red         = pick_value(narrow);
    it.green       = pick_value(narrow);
    it.blue        = pick_value(narrow);
    it.bin_select  = pick_value(narrow);
    return it;
  endfunction

  // Default registers select the gray sample; reads of bins 0 and 255 check the clearing pass.
  task automatic test_reset_state();
    send_item(pixel_item(1'b1, 8'd7, 8'd70, 8'd71, 8'd72));
    send_item(read_item(8'd7));
    send_item(read_item(8'd0));
    send_item(read_item(8'd255));
  endtask

  task automatic test_gray_image();
    wait_for_reports();
    cfg_write(ADDR_PLANE, PLANE_BLUE);
    cfg_write(ADDR_IMAGE_KIND, KIND_GRAY);
    send_item(pixel_item(1'b1, 8'd0, 8'd255, 8'd255, 8'd200));
    send_item(pixel_item(1'b1, 8'd255, 8'd0, 8'd0, 8'd0));
    send_item(pixel_item(1'b0, 8'd0, 8'd0, 8'd0, 8'd0));
    send_item(read_item(8'd0));
    send_item(read_item(8'd255));
    send_item(read_item(8'd200));
  endtask

  task automatic test_color_planes();
    logic [PLANE_BITS-1:0] p;
    wait_for_reports();
    cfg_write(ADDR_IMAGE_KIND, KIND_COLOR);
    for (int i = 0; i < 4; i++) begin
      p = PLANE_BITS'(i);
      wait_for_reports();
      cfg_write(ADDR_PLANE, p);
      send_item(pixel_item(1'b1, 8'd10, 8'd20, 8'd30, 8'd40));
      send_item(read_item(8'(10 * (i + 1))));
    end
  endtask

  // Bitmap images and the unused kind count nothing.
  task automatic test_uncounted_kinds();
    wait_for_reports();
    cfg_write(ADDR_IMAGE_KIND, KIND_BITMAP);
    send_item(pixel_item(1'b1, 8'd50, 8'd50, 8'd50, 8'd50));
    wait_for_reports();
    cfg_write(ADDR_IMAGE_KIND, KIND_UNUSED);
    send_item(pixel_item(1'b1, 8'd60, 8'd60, 8'd60, 8'd60));
    send_item(read_item(8'd50));
    send_item(read_item(8'd60));
  endtask

  // Transfers on one bin in consecutive cycles exercise the read-modify-write forwarding.
  task automatic test_back_to_back();
    wait_for_reports();
    cfg_write(ADDR_IMAGE_KIND, KIND_GRAY);
    no_idle = 1'b1;
    repeat (3) send_item(pixel_item(1'b1, 8'd99, 8'd1, 8'd2, 8'd3));
    send_item(read_item(8'd99));
    send_item(pixel_item(1'b1, 8'd99, 8'd4, 8'd5, 8'd6));
    send_item(read_item(8'd99));
    no_idle = 1'b0;
  endtask

  // Each phase drains the core, picks a register setting and sends a burst of random items.
  task automatic test_random_traffic();
    logic [KIND_BITS-1:0]  kind;
    logic [PLANE_BITS-1:0] plane;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_for_reports();
      if (phase < 16) begin
        kind  = KIND_BITS'(phase % 4);
        plane = PLANE_BITS'(phase / 4);
      end else begin
        kind  = KIND_BITS'($urandom_range(3));
        plane = PLANE_BITS'($urandom_range(3));
      end
      cfg_write(ADDR_IMAGE_KIND, kind);
      cfg_write(ADDR_PLANE, plane);
      no_idle = (phase == 9);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        send_item(random_item(phase % 2 == 1));
      end
      no_idle = 1'b0;
    end
  endtask

  always @(posedge clk) begin
    out_ready <= no_idle || ($urandom_range(99) >= IDLE_PERCENT);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_reports.size() == 0) begin
        report_mismatch($sformatf("unexpected report: bin %0d total %0d",
                                  out_bin_number, out_bin_total));
      end else begin
        oldest_report = pending_reports.pop_front();
        if (out_bin_number !== oldest_report.bin_number) begin
          report_mismatch($sformatf("bin_number %0d, predicted %0d",
                                    out_bin_number, oldest_report.bin_number));
        end
        if (out_bin_total !== oldest_report.bin_total) begin
          report_mismatch($sformatf("bin %0d: bin_total %0d, predicted %0d",
                                    oldest_report.bin_number, out_bin_total,
                                    oldest_report.bin_total));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d reports outstanding",
               cycle_count, pending_reports.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_mode         <= MODE_ACCUMULATE;
    in_pixel_valid  <= 1'b0;
    in_gray_sample  <= '0;
    in_red_sample   <= '0;
    in_green_sample <= '0;
    in_blue_sample  <= '0;
    in_bin_select   <= '0;
    out_ready       <= 1'b0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    cycle_count     = 0;
    error_count     = 0;
    no_idle         = 1'b0;
    kind_reg        = KIND_GRAY;
    plane_reg       = PLANE_GRAY;
    foreach (hist_counts[i]) hist_counts[i] = '0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_gray_image();
    test_color_planes();
    test_uncounted_kinds();
    test_back_to_back();
    test_random_traffic();
    wait_for_reports();

    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/phs_pkg.sv
design/phs_bin_ram.sv
design/pixel_histogram_plane_select_core.sv
verif/tb_pixel_histogram_plane_select_core.sv
